[rtl/ipsa_pkg.sv]
// Package with the types, codes and constants of the IPS patch stream applier.
`timescale 1ns / 1ps

package ipsa_pkg;

   localparam logic [24:0] MAX_IMAGE_BYTES = 25'd16777216;
   localparam logic [24:0] INIT_SIZE_RESET = 25'd524288;
   localparam logic [23:0] EOF_MARK        = 24'h454F46;
   localparam logic [3:0]  HEADER_BYTES    = 4'd8;
   localparam int          QUEUE_DEPTH     = 4;
   localparam int          QPTR_W          = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_OFFSET = 3'd1,
      PH_LENGTH = 3'd2,
      PH_RLE    = 3'd3,
      PH_DATA   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_FILL   = 2'd1,
      KIND_DONE   = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE        = 3'd0,
      ERR_BAD_HEADER  = 3'd1,
      ERR_NO_EOF      = 3'd2,
      ERR_SHORT_HDR   = 3'd3,
      ERR_SHORT_RLE   = 3'd4,
      ERR_RLE_RANGE   = 3'd5,
      ERR_DATA_RANGE  = 3'd6
   } err_type;

   typedef struct packed {
      logic [7:0] patch_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [23:0] target_address;
      logic [15:0] fill_count;
      logic [7:0]  data_value;
      logic [24:0] final_size;
      err_type     error_code;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic [7:0] magic_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0: b = 8'h50;
         3'd1: b = 8'h41;
         3'd2: b = 8'h54;
         3'd3: b = 8'h43;
         3'd4: b = 8'h48;
         3'd5: b = 8'h50;
         3'd6: b = 8'h41;
         default: b = 8'h54;
      endcase
      return b;
   endfunction

endpackage

[rtl/ipsa_parser.sv]
// Record parser: phase machine, range checks and result generation for one byte.
`timescale 1ns / 1ps

module ipsa_parser
   import ipsa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  req_type     req_data,
   input  logic        csr_write,
   input  logic [24:0] csr_data,
   output push_type    push
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  field_index_ff, field_index_in;
   logic [3:0]  bytes_seen_ff, bytes_seen_in;
   logic [23:0] record_offset_ff, record_offset_in;
   logic [15:0] record_length_ff, record_length_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [24:0] image_size_ff, image_size_in;
   logic        stream_closed_ff, stream_closed_in;
   logic [24:0] init_size_ff, init_size_in;

   logic [7:0]  b;
   logic [2:0]  fi_inc;
   logic [23:0] shifted_offset;
   logic [15:0] shifted_length;
   logic [15:0] claim_length;
   logic [24:0] need;
   logic        claim_ok;
   logic        claim_grow;
   logic [23:0] write_address;
   logic        take_valid;
   rsp_type     take_res;
   logic        end_valid;
   rsp_type     end_res;

   assign b              = req_data.patch_byte;
   assign fi_inc         = field_index_ff + 3'd1;
   assign shifted_offset = {record_offset_ff[15:0], b};
   assign shifted_length = {record_length_ff[7:0], b};
   assign claim_length   = (phase_ff == PH_LENGTH) ? shifted_length : record_length_ff;
   assign need           = {1'b0, record_offset_ff} + {9'd0, claim_length};
   assign claim_ok       = (need <= image_size_ff) || (need <= MAX_IMAGE_BYTES);
   assign claim_grow     = need > image_size_ff;
   assign write_address  = record_offset_ff + {8'd0, record_length_ff - bytes_left_ff};

   always_comb begin
      phase_in         = phase_ff;
      field_index_in   = field_index_ff;
      bytes_seen_in    = bytes_seen_ff;
      record_offset_in = record_offset_ff;
      record_length_in = record_length_ff;
      bytes_left_in    = bytes_left_ff;
      image_size_in    = image_size_ff;
      stream_closed_in = stream_closed_ff;
      init_size_in     = csr_write ? csr_data : init_size_ff;
      take_valid       = 1'b0;
      take_res         = '0;
      end_valid        = 1'b0;
      end_res          = '0;

      if (step) begin
         if (!stream_closed_ff) begin
            if (bytes_seen_ff < HEADER_BYTES) begin
               bytes_seen_in = bytes_seen_ff + 4'd1;
            end
            case (phase_ff)
               PH_HEADER: begin
                  if (b != magic_byte(field_index_ff)) begin
                     take_valid          = 1'b1;
                     take_res.kind       = KIND_ERROR;
                     take_res.error_code = ERR_BAD_HEADER;
                     stream_closed_in    = 1'b1;
                  end else if (fi_inc >= 3'd5) begin
                     phase_in         = PH_OFFSET;
                     field_index_in   = '0;
                     record_offset_in = '0;
                  end else begin
                     field_index_in = fi_inc;
                  end
               end
               PH_OFFSET: begin
                  record_offset_in = shifted_offset;
                  field_index_in   = fi_inc;
                  if (fi_inc >= 3'd3) begin
                     if (shifted_offset == EOF_MARK) begin
                        take_valid          = 1'b1;
                        take_res.kind       = KIND_DONE;
                        take_res.final_size = image_size_ff;
                        stream_closed_in    = 1'b1;
                     end else begin
                        phase_in         = PH_LENGTH;
                        field_index_in   = '0;
                        record_length_in = '0;
                     end
                  end
               end
               PH_LENGTH: begin
                  record_length_in = shifted_length;
                  field_index_in   = fi_inc;
                  if (fi_inc >= 3'd2) begin
                     field_index_in = '0;
                     if (shifted_length == 16'd0) begin
                        phase_in = PH_RLE;
                     end else if (!claim_ok) begin
                        take_valid          = 1'b1;
                        take_res.kind       = KIND_ERROR;
                        take_res.error_code = ERR_DATA_RANGE;
                        stream_closed_in    = 1'b1;
                     end else begin
                        if (claim_grow) begin
                           image_size_in = need;
                        end
                        phase_in      = PH_DATA;
                        bytes_left_in = shifted_length;
                     end
                  end
               end
               PH_RLE: begin
                  if (field_index_ff < 3'd2) begin
                     record_length_in = shifted_length;
                     field_index_in   = fi_inc;
                  end else if (record_length_ff == 16'd0 || !claim_ok) begin
                     take_valid          = 1'b1;
                     take_res.kind       = KIND_ERROR;
                     take_res.error_code = ERR_RLE_RANGE;
                     stream_closed_in    = 1'b1;
                  end else begin
                     if (claim_grow) begin
                        image_size_in = need;
                     end
                     take_valid              = 1'b1;
                     take_res.kind           = KIND_FILL;
                     take_res.target_address = record_offset_ff;
                     take_res.fill_count     = record_length_ff;
                     take_res.data_value     = b;
                     phase_in                = PH_OFFSET;
                     field_index_in          = '0;
                     record_offset_in        = '0;
                  end
               end
               PH_DATA: begin
                  take_valid              = 1'b1;
                  take_res.kind           = KIND_WRITE;
                  take_res.target_address = write_address;
                  take_res.data_value     = b;
                  if (bytes_left_ff <= 16'd1) begin
                     bytes_left_in    = '0;
                     phase_in         = PH_OFFSET;
                     field_index_in   = '0;
                     record_offset_in = '0;
                  end else begin
                     bytes_left_in = bytes_left_ff - 16'd1;
                  end
               end
               default: begin
                  take_valid          = 1'b1;
                  take_res.kind       = KIND_ERROR;
                  take_res.error_code = ERR_BAD_HEADER;
                  stream_closed_in    = 1'b1;
               end
            endcase
         end
         if (req_data.stream_end) begin
            if (!stream_closed_in) begin
               end_valid    = 1'b1;
               end_res.kind = KIND_ERROR;
               if (bytes_seen_in < HEADER_BYTES) begin
                  end_res.error_code = ERR_BAD_HEADER;
               end else begin
                  case (phase_in)
                     PH_OFFSET: end_res.error_code = ERR_NO_EOF;
                     PH_LENGTH: end_res.error_code = ERR_SHORT_HDR;
                     PH_RLE:    end_res.error_code = ERR_SHORT_RLE;
                     PH_DATA:   end_res.error_code = ERR_DATA_RANGE;
                     default:   end_res.error_code = ERR_BAD_HEADER;
                  endcase
               end
            end
            phase_in         = PH_HEADER;
            field_index_in   = '0;
            bytes_seen_in    = '0;
            record_offset_in = '0;
            record_length_in = '0;
            bytes_left_in    = '0;
            image_size_in    = init_size_ff;
            stream_closed_in = 1'b0;
         end
      end else if (csr_write && bytes_seen_ff == 4'd0) begin
         image_size_in = csr_data;
      end
   end

   always_comb begin
      push = '0;
      if (take_valid && end_valid) begin
         push.count              = 2'd2;
         push.first              = take_res;
         push.second             = end_res;
         push.second.last_of_run = 1'b1;
      end else if (take_valid) begin
         push.count             = 2'd1;
         push.first             = take_res;
         push.first.last_of_run = 1'b1;
      end else if (end_valid) begin
         push.count             = 2'd1;
         push.first             = end_res;
         push.first.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         field_index_ff   <= '0;
         bytes_seen_ff    <= '0;
         record_offset_ff <= '0;
         record_length_ff <= '0;
         bytes_left_ff    <= '0;
         image_size_ff    <= INIT_SIZE_RESET;
         stream_closed_ff <= 1'b0;
         init_size_ff     <= INIT_SIZE_RESET;
      end else begin
         phase_ff         <= phase_in;
         field_index_ff   <= field_index_in;
         bytes_seen_ff    <= bytes_seen_in;
         record_offset_ff <= record_offset_in;
         record_length_ff <= record_length_in;
         bytes_left_ff    <= bytes_left_in;
         image_size_ff    <= image_size_in;
         stream_closed_ff <= stream_closed_in;
         init_size_ff     <= init_size_in;
      end
   end

endmodule

[rtl/ipsa_result_queue.sv]
// Small result queue that takes up to two results per cycle and hands out one.
`timescale 1ns / 1ps

module ipsa_result_queue
   import ipsa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     has_room,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   rsp_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              pop;
   logic [QPTR_W-1:0] wptr_next;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = entry_ff[rptr_ff];
   assign has_room  = count_ff <= (QPTR_W + 1)'(QUEUE_DEPTH - 2);
   assign wptr_next = wptr_ff + QPTR_W'(1);

   always_comb begin
      wptr_in  = wptr_ff + QPTR_W'(push.count);
      rptr_in  = pop ? rptr_ff + QPTR_W'(1) : rptr_ff;
      count_in = count_ff + (QPTR_W + 1)'(push.count) - (QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wptr_next] <= push.second;
      end
   end

endmodule

[rtl/ips_patch_stream_applier.sv]
// Top level of the IPS patch stream applier.
`timescale 1ns / 1ps

// The patch arrives one byte per transfer on the req_ channel, with stream_end
// set on the last byte. Results leave on the rsp_ channel: byte writes, fill
// runs, a finish record with the final image size, or an error record.
// One byte causes at most two results, and last_of_run marks the last of them.
// A byte is parsed in the cycle it is taken, and its results are registered
// into the result queue that drives rsp_.
// The throughput is one byte per cycle, set by the single parser step and the
// four-entry result queue: req_ready stays high while the queue holds at most
// two results, and it drops when the receiver stalls and the queue fills.
// The csr_ channel writes the initial image size. It is always ready; the user
// must write it only while the block is idle, which the block itself does not
// enforce. It is loaded into the working size at the start of every stream.
// Reset is synchronous. It empties the queue, returns the parser to the header
// phase and sets the initial image size to 512 KiB.
module ips_patch_stream_applier
   import ipsa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [24:0] csr_data
);

   push_type push;
   logic     has_room;
   logic     step;

   assign req_ready = has_room;
   assign csr_ready = 1'b1;
   assign step      = req_valid && req_ready;

   ipsa_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .push      (push)
   );

   ipsa_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/ipsa_checker.sv]
// Port checker for the IPS patch stream applier and its bind statement.
`timescale 1ns / 1ps

module ipsa_checker
   import ipsa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input req_type     req_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input rsp_type     rsp_data,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [24:0] csr_data
);

   // A stalled result must hold until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // The queue is empty right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // Only error records carry an error code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_ERROR |-> rsp_data.error_code == ERR_NONE)
      else $error("error code on a non-error result");

   // A fill run never has a zero count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_FILL |-> rsp_data.fill_count != 16'd0)
      else $error("fill run with zero count");

   // The input stalls only while results are waiting.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result waiting");

endmodule

bind ips_patch_stream_applier ipsa_checker u_checker (.*);

[tb/sv/ipsa_patch_checker.sv]
// Checker that predicts and compares the results of the IPS patch stream applier.
`timescale 1ns / 1ps

module ipsa_patch_checker
   import ipsa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [24:0] csr_data,
   output int          pending,
   output int          parsed_bytes,
   output int          mismatches
);

   localparam logic [39:0] PATCH_TAG    = "PATCH";
   localparam int          TAG_LEN      = 5;
   localparam int          OFFSET_BYTES = 3;
   localparam int          LENGTH_BYTES = 2;

   logic [24:0] base_size;
   phase_type   ph;
   int unsigned field_pos;
   int unsigned seen;
   logic [23:0] rec_offset;
   logic [15:0] rec_length;
   logic [15:0] remaining;
   logic [24:0] cur_size;
   logic        closed;

   rsp_type expected_ops[$];
   rsp_type step_ops[$];
   int      n_parsed = 0;
   int      n_bad = 0;

   assign mismatches = n_bad;

   task automatic report_mismatch(input string what);
      n_bad++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   function automatic void note_result(input kind_type k, input logic [23:0] addr,
                                       input logic [15:0] cnt, input logic [7:0] val,
                                       input logic [24:0] size, input err_type e);
      rsp_type r;
      r.kind = k;
      r.target_address = addr;
      r.fill_count = cnt;
      r.data_value = val;
      r.final_size = size;
      r.error_code = e;
      r.last_of_run = 1'b0;
      if (step_ops.size() < 2) begin
         step_ops.push_back(r);
      end
   endfunction

   function automatic void raise_error(input err_type e);
      note_result(KIND_ERROR, '0, '0, '0, '0, e);
      closed = 1'b1;
   endfunction

   function automatic void restart_stream();
      ph = PH_HEADER;
      field_pos = 0;
      seen = 0;
      rec_offset = '0;
      rec_length = '0;
      remaining = '0;
      cur_size = base_size;
      closed = 1'b0;
   endfunction

   // Grows the image to cover the record; fails if the record passes the limit.
   function automatic bit claim_span(input logic [23:0] o, input logic [15:0] len);
      logic [25:0] need;
      need = o + len;
      if (need <= cur_size) return 1'b1;
      if (need > MAX_IMAGE_BYTES) return 1'b0;
      cur_size = need[24:0];
      return 1'b1;
   endfunction

   function automatic void start_record();
      ph = PH_OFFSET;
      field_pos = 0;
      rec_offset = '0;
   endfunction

   function automatic void take_byte(input logic [7:0] b);
      case (ph)
         PH_HEADER: begin
            if (b != PATCH_TAG[39 - 8*field_pos -: 8]) begin
               raise_error(ERR_BAD_HEADER);
               return;
            end
            field_pos++;
            if (field_pos >= TAG_LEN) start_record();
         end
         PH_OFFSET: begin
            rec_offset = {rec_offset[15:0], b};
            field_pos++;
            if (field_pos >= OFFSET_BYTES) begin
               if (rec_offset == EOF_MARK) begin
                  note_result(KIND_DONE, '0, '0, '0, cur_size, ERR_NONE);
                  closed = 1'b1;
                  return;
               end
               ph = PH_LENGTH;
               field_pos = 0;
               rec_length = '0;
            end
         end
         PH_LENGTH: begin
            rec_length = {rec_length[7:0], b};
            field_pos++;
            if (field_pos >= LENGTH_BYTES) begin
               field_pos = 0;
               if (rec_length == 0) begin
                  ph = PH_RLE;
               end else if (!claim_span(rec_offset, rec_length)) begin
                  raise_error(ERR_DATA_RANGE);
               end else begin
                  ph = PH_DATA;
                  remaining = rec_length;
               end
            end
         end
         PH_RLE: begin
            if (field_pos < LENGTH_BYTES) begin
               rec_length = {rec_length[7:0], b};
               field_pos++;
               return;
            end
            if (rec_length == 0 || !claim_span(rec_offset, rec_length)) begin
               raise_error(ERR_RLE_RANGE);
               return;
            end
            note_result(KIND_FILL, rec_offset, rec_length, b, '0, ERR_NONE);
            start_record();
         end
         PH_DATA: begin
            note_result(KIND_WRITE, rec_offset + (rec_length - remaining), '0, b, '0,
                        ERR_NONE);
            if (remaining > 0) remaining--;
            if (remaining == 0) start_record();
         end
         default: raise_error(ERR_BAD_HEADER);
      endcase
   endfunction

   function automatic void parse_patch_byte(input req_type item);
      step_ops.delete();
      if (!closed) begin
         n_parsed++;
         if (seen < HEADER_BYTES) seen++;
         take_byte(item.patch_byte);
      end
      if (item.stream_end) begin
         if (!closed) begin
            if (seen < HEADER_BYTES) begin
               raise_error(ERR_BAD_HEADER);
            end else begin
               case (ph)
                  PH_OFFSET: raise_error(ERR_NO_EOF);
                  PH_LENGTH: raise_error(ERR_SHORT_HDR);
                  PH_RLE:    raise_error(ERR_SHORT_RLE);
                  PH_DATA:   raise_error(ERR_DATA_RANGE);
                  default:   raise_error(ERR_BAD_HEADER);
               endcase
            end
         end
         restart_stream();
      end
      if (step_ops.size() > 0) begin
         step_ops[step_ops.size() - 1].last_of_run = 1'b1;
      end
      foreach (step_ops[i]) expected_ops.push_back(step_ops[i]);
   endfunction

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_ops.size() == 0) begin
         report_mismatch($sformatf("result of kind %0d with nothing expected", got.kind));
         return;
      end
      want = expected_ops.pop_front();
      if (got.kind !== want.kind)
         report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.target_address !== want.target_address)
         report_mismatch($sformatf("target_address %h, expected %h",
                                   got.target_address, want.target_address));
      if (got.fill_count !== want.fill_count)
         report_mismatch($sformatf("fill_count %0d, expected %0d",
                                   got.fill_count, want.fill_count));
      if (got.data_value !== want.data_value)
         report_mismatch($sformatf("data_value %h, expected %h",
                                   got.data_value, want.data_value));
      if (got.final_size !== want.final_size)
         report_mismatch($sformatf("final_size %0d, expected %0d",
                                   got.final_size, want.final_size));
      if (got.error_code !== want.error_code)
         report_mismatch($sformatf("error_code %0d, expected %0d",
                                   got.error_code, want.error_code));
      if (got.last_of_run !== want.last_of_run)
         report_mismatch($sformatf("last_of_run %0d, expected %0d",
                                   got.last_of_run, want.last_of_run));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         base_size = INIT_SIZE_RESET;
         restart_stream();
         expected_ops.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (csr_valid && csr_ready) begin
            base_size = csr_data;
            if (seen == 0) cur_size = base_size;
         end
         if (req_valid && req_ready) parse_patch_byte(req_data);
      end
      pending <= expected_ops.size();
      parsed_bytes <= n_parsed;
   end

endmodule

[tb/sv/tb.sv]
// Top of the testbench: patch stream stimulus, result receiver and verdict.
`timescale 1ns / 1ps

module tb
   import ipsa_pkg::*;
();

   localparam logic [39:0] PATCH_TAG    = "PATCH";
   localparam int          TAG_LEN      = 5;
   localparam int          PARSE_TARGET = 1250;
   localparam int          BYTE_CAP     = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [24:0] csr_data = '0;
   int          pending;
   int          parsed_bytes;
   int          mismatches;

   req_type     stream_q[$];
   logic [24:0] image_base = INIT_SIZE_RESET;
   bit          burst = 1'b0;
   int          sent_total = 0;
   int unsigned rsp_seen;
   int unsigned rsp_gap;
   int unsigned rsp_hold;
   int unsigned rsp_draw;

   always #6 clock = ~clock;

   ips_patch_stream_applier uut (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_data
   );

   ipsa_patch_checker chk (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_data,
      .pending, .parsed_bytes, .mismatches
   );

   // The receiver stalls at random and twice holds off long enough to back up the input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap <= 0;
         rsp_hold <= 0;
         rsp_seen <= 0;
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end else if (rsp_valid && rsp_ready) begin
         rsp_seen <= rsp_seen + 1;
         if (rsp_seen == 150 || rsp_seen == 450) begin
            rsp_hold <= 200;
            rsp_ready <= 1'b0;
         end else begin
            rsp_draw = ((rsp_seen % 300) < 60) ? 0 : $urandom_range(0, 9);
            rsp_gap <= rsp_draw;
            rsp_ready <= (rsp_draw == 0);
         end
      end else if (rsp_gap != 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_ready <= (rsp_gap == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_byte(input req_type item);
      int unsigned gap;
      gap = burst ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_image_size(input logic [24:0] size);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      image_base = size;
   endtask

   function automatic logic [24:0] pick_size();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return MAX_IMAGE_BYTES;
         2: return INIT_SIZE_RESET;
         3: return 25'($urandom_range(0, 4096));
         default: return 25'($urandom_range(0, 16777216));
      endcase
   endfunction

   function automatic void put_byte(input logic [7:0] b);
      req_type item;
      item.patch_byte = b;
      item.stream_end = 1'b0;
      stream_q.push_back(item);
   endfunction

   function automatic void mark_end();
      req_type item;
      item = stream_q.pop_back();
      item.stream_end = 1'b1;
      stream_q.push_back(item);
   endfunction

   // A bad position of TAG_LEN or more gives a clean header.
   function automatic void put_header(input int bad_pos);
      logic [7:0] flip;
      for (int i = 0; i < TAG_LEN; i++) begin
         if (i == bad_pos) begin
            flip = 8'($urandom_range(1, 255));
            put_byte(PATCH_TAG[39 - 8*i -: 8] ^ flip);
            return;
         end
         put_byte(PATCH_TAG[39 - 8*i -: 8]);
      end
   endfunction

   function automatic void put_offset(input logic [23:0] o);
      put_byte(o[23:16]);
      put_byte(o[15:8]);
      put_byte(o[7:0]);
   endfunction

   function automatic logic [23:0] pick_offset();
      logic [23:0] o;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: o = 24'($urandom_range(0, 4095));
         4, 5: o = image_base[23:0] + 24'($urandom_range(0, 32)) - 24'd16;
         6: o = 24'($urandom);
         7: o = 24'hFFFFFF - 24'($urandom_range(0, 8));
         8: o = EOF_MARK ^ (24'd1 << $urandom_range(0, 23));
         default: o = 24'($urandom_range(0, 255));
      endcase
      return o;
   endfunction

   // Each record function returns 1 when the record closes the stream with an error.
   function automatic bit put_data_record();
      logic [23:0] o;
      int unsigned len;
      o = pick_offset();
      case ($urandom_range(0, 19))
         0: begin
            o = 24'hFFFFFF - 24'($urandom_range(0, 300));
            len = $urandom_range(0, 1) ? 65535 : $urandom_range(1, 65535);
         end
         1, 2: len = $urandom_range(7, 40);
         default: len = $urandom_range(1, 6);
      endcase
      if (o + len > MAX_IMAGE_BYTES) begin
         put_offset(o);
         put_byte(len[15:8]);
         put_byte(len[7:0]);
         return 1'b1;
      end
      if (len > 40) len = $urandom_range(1, 40);
      put_offset(o);
      put_byte(len[15:8]);
      put_byte(len[7:0]);
      repeat (len) put_byte(8'($urandom));
      return 1'b0;
   endfunction

   function automatic bit put_fill_record();
      logic [23:0] o;
      int unsigned cnt;
      o = pick_offset();
      case ($urandom_range(0, 19))
         0, 1: cnt = 0;
         2, 3: cnt = 65535;
         4, 5, 6: cnt = $urandom_range(1, 65535);
         default: cnt = $urandom_range(1, 300);
      endcase
      put_offset(o);
      put_byte(8'h00);
      put_byte(8'h00);
      put_byte(cnt[15:8]);
      put_byte(cnt[7:0]);
      put_byte(8'($urandom));
      return (cnt == 0 || o + cnt > MAX_IMAGE_BYTES);
   endfunction

   // Mostly complete patches; the rest are truncated, lack the end marker,
   // carry a corrupt header or are plain noise.
   function automatic void build_stream();
      int unsigned shape;
      int unsigned nrec;
      int unsigned cut;
      bit dead;
      stream_q.delete();
      shape = $urandom_range(0, 19);
      dead = 1'b0;
      if (shape == 18) begin
         repeat ($urandom_range(1, 10)) put_byte(8'($urandom));
      end else if (shape == 17) begin
         put_header($urandom_range(0, TAG_LEN - 1));
         repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
      end else begin
         put_header(TAG_LEN);
         nrec = $urandom_range(0, 4);
         for (int i = 0; i < nrec && !dead; i++) begin
            dead = ($urandom_range(0, 2) == 0) ? put_fill_record() : put_data_record();
         end
         if (!dead && shape != 16) put_offset(EOF_MARK);
         if (shape == 14 || shape == 15 || shape == 19) begin
            cut = $urandom_range(1, stream_q.size());
            while (stream_q.size() > cut) void'(stream_q.pop_back());
         end else if (dead || (shape <= 13 && $urandom_range(0, 2) == 0)) begin
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
         end
      end
      mark_end();
   endfunction

   task automatic send_stream();
      int unsigned cfg_at;
      cfg_at = ($urandom_range(0, 24) == 0) ? $urandom_range(1, stream_q.size()) : 0;
      foreach (stream_q[i]) begin
         if (cfg_at != 0 && i == cfg_at) write_image_size(pick_size());
         send_byte(stream_q[i]);
      end
      sent_total += stream_q.size();
   endtask

   initial begin
      int guard;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Write at the top byte of the image from an empty image, then finish.
      write_image_size('0);
      stream_q.delete();
      put_header(TAG_LEN);
      put_offset(24'hFFFFFF);
      put_byte(8'h00);
      put_byte(8'h01);
      put_byte(8'hFF);
      put_offset(EOF_MARK);
      mark_end();
      send_stream();

      // A stream too short to hold a header.
      stream_q.delete();
      put_byte(8'h50);
      mark_end();
      send_stream();

      // A wrong first byte, then an ignored byte that ends the stream.
      stream_q.delete();
      put_byte(8'h00);
      put_byte(8'hFF);
      mark_end();
      send_stream();

      // A data record cut short: a write and its error in the same transfer.
      stream_q.delete();
      put_header(TAG_LEN);
      put_offset(24'h000010);
      put_byte(8'h00);
      put_byte(8'h02);
      put_byte(8'hAA);
      mark_end();
      send_stream();

      write_image_size(MAX_IMAGE_BYTES);

      while (parsed_bytes < PARSE_TARGET && sent_total < BYTE_CAP) begin
         if ($urandom_range(0, 5) == 0) write_image_size(pick_size());
         build_stream();
         burst = ($urandom_range(0, 3) == 0);
         send_stream();
      end
      req_valid <= 1'b0;

      guard = 0;
      while (pending != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      if (pending != 0) begin
         $display("%0d expected results never arrived", pending);
      end
      if (mismatches == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
